>>> design/irpw_pkg.sv
// Shared types, constants and helpers for the IR pulse-width frame decoder.
// No dependencies; every other design file but irpw_line_if refers to this package by scoped names.
package irpw_pkg;

	// Frame and timer geometry
	localparam int FRAME_BITS      = 12;
	localparam int TIMER_WIDTH     = 16;
	localparam int CFG_WIDTH       = 16;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int WORD_WIDTH      = 12;
	localparam int CMD_WIDTH       = 7;
	localparam int ADDR_WIDTH      = WORD_WIDTH - CMD_WIDTH;
	localparam int KEY_WIDTH       = 2;

	typedef logic [TIMER_WIDTH-1:0] ticks_t;
	typedef logic [FRAME_BITS:0]    mask_t;
	typedef logic [FRAME_BITS-1:0]  bits_t;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_FIRST_DELAY = 2'd0,
		CFG_ZERO_PERIOD = 2'd1,
		CFG_ONE_PERIOD  = 2'd2
	} cfg_index_t;

	// Reset values of the timing registers
	localparam ticks_t FIRST_DELAY_RESET = 16'd3900;
	localparam ticks_t ZERO_PERIOD_RESET = 16'd1200;
	localparam ticks_t ONE_PERIOD_RESET  = 16'd1800;

	// Known command codes
	localparam logic [CMD_WIDTH-1:0] CMD_VOL_DOWN = 7'd19;
	localparam logic [CMD_WIDTH-1:0] CMD_VOL_UP   = 7'd18;
	localparam logic [CMD_WIDTH-1:0] CMD_POWER    = 7'd21;

	typedef enum logic [KEY_WIDTH-1:0] {
		KEY_OTHER    = 2'd0,
		KEY_VOL_DOWN = 2'd1,
		KEY_VOL_UP   = 2'd2,
		KEY_POWER    = 2'd3
	} key_t;

	// Timing setup handed from the register file to the frame sequencer
	typedef struct packed {
		ticks_t first_delay;
		ticks_t zero_period;
		ticks_t one_period;
	} timing_t;

	// One decoded frame
	typedef struct packed {
		logic [WORD_WIDTH-1:0] frame_word;
		logic [CMD_WIDTH-1:0]  command_code;
		logic [ADDR_WIDTH-1:0] device_address;
		key_t                  key_kind;
	} frame_t;

	function automatic key_t key_of(input logic [CMD_WIDTH-1:0] cmd);
		key_t k;
		case (cmd)
			CMD_VOL_DOWN: k = KEY_VOL_DOWN;
			CMD_VOL_UP:   k = KEY_VOL_UP;
			CMD_POWER:    k = KEY_POWER;
			default:      k = KEY_OTHER;
		endcase
		return k;
	endfunction

endpackage

>>> design/irpw_line_if.sv
// Valid/ready channel carrying one IR line sample per transfer.
// Stands alone; used by the decoder top level.
interface irpw_line_if;
	logic valid;
	logic ready;
	logic line_level;

	modport source(output valid, output line_level, input ready);
	modport sink(input valid, input line_level, output ready);
endinterface

>>> design/irpw_frame_if.sv
// Valid/ready channel carrying one decoded IR frame per transfer.
// Field widths come from irpw_pkg.
interface irpw_frame_if;
	logic                                  valid;
	logic                                  ready;
	logic [irpw_pkg::WORD_WIDTH-1:0]       frame_word;
	logic [irpw_pkg::CMD_WIDTH-1:0]        command_code;
	logic [irpw_pkg::ADDR_WIDTH-1:0]       device_address;
	logic [irpw_pkg::KEY_WIDTH-1:0]        key_kind;

	modport source(output valid, output frame_word, output command_code,
		output device_address, output key_kind, input ready);
	modport sink(input valid, input frame_word, input command_code,
		input device_address, input key_kind, output ready);
endinterface

>>> design/irpw_frame_fsm.sv
// Frame sequencer: edge detect, sample countdown, bit gathering and frame decode.
// Depends on irpw_pkg. Advances by one line sample on each cycle that step is high.
module irpw_frame_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              line_level,
	input  irpw_pkg::timing_t timing,
	output logic              res_valid,
	output irpw_pkg::frame_t  res
);

	logic             waiting_q, waiting_d;
	logic             prev_q;
	irpw_pkg::ticks_t ticks_q, ticks_d, ticks_dec;
	irpw_pkg::mask_t  mask_q, mask_d;
	irpw_pkg::bits_t  bits_q, bits_d;
	logic             frame_done;

	// Next-state logic for one sample
	always_comb begin
		waiting_d  = waiting_q;
		ticks_d    = ticks_q;
		mask_d     = mask_q;
		bits_d     = bits_q;
		frame_done = 1'b0;
		ticks_dec  = ticks_q - 1'b1;
		if (waiting_q) begin
			// falling edge starts a frame
			if (prev_q && !line_level) begin
				waiting_d = 1'b0;
				ticks_d   = timing.first_delay;
				mask_d    = irpw_pkg::mask_t'(1);
				bits_d    = '0;
			end
		end else begin
			ticks_d = ticks_dec;
			if (ticks_dec == '0) begin
				if (mask_q[irpw_pkg::FRAME_BITS] || mask_q == '0) begin
					// slot after the last bit: emit and rearm
					frame_done = 1'b1;
					waiting_d  = 1'b1;
					mask_d     = '0;
					bits_d     = '0;
				end else begin
					// low sample is a one bit
					if (!line_level) begin
						bits_d  = bits_q | mask_q[irpw_pkg::FRAME_BITS-1:0];
						ticks_d = timing.one_period;
					end else begin
						ticks_d = timing.zero_period;
					end
					mask_d = {mask_q[irpw_pkg::FRAME_BITS-1:0], 1'b0};
				end
			end
		end
	end

	// Decoded fields come straight from the gathered bits
	assign res_valid          = step && frame_done;
	assign res.frame_word     = bits_q[irpw_pkg::WORD_WIDTH-1:0];
	assign res.command_code   = bits_q[irpw_pkg::CMD_WIDTH-1:0];
	assign res.device_address = bits_q[irpw_pkg::WORD_WIDTH-1:irpw_pkg::CMD_WIDTH];
	assign res.key_kind       = irpw_pkg::key_of(bits_q[irpw_pkg::CMD_WIDTH-1:0]);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b1;
			prev_q    <= 1'b1;
			ticks_q   <= '0;
			mask_q    <= '0;
			bits_q    <= '0;
		end else if (step) begin
			waiting_q <= waiting_d;
			prev_q    <= line_level;
			ticks_q   <= ticks_d;
			mask_q    <= mask_d;
			bits_q    <= bits_d;
		end
	end

endmodule

>>> design/ir_pulse_width_frame_decoder.sv
// IR pulse-width frame decoder top level: timing registers, input stage, output queue.
// Depends on irpw_pkg, irpw_line_if, irpw_frame_if and irpw_frame_fsm.

// One line sample is taken per transfer on the samples channel, and a new sample
// can be taken every clock cycle. A transferred sample sits in an input register
// and is folded into the frame sequencer once the output queue has room; when it
// completes a frame, the decoded word enters a two-entry output queue and is
// offered on the frames channel the cycle after that. The input only stalls while
// both queue entries hold frames that have not been taken. Timing registers (first
// sample delay, zero and one bit periods, in samples) are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them only while the block is
// idle, which the block itself does not enforce; a value of zero acts as 65536 samples.
module ir_pulse_width_frame_decoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	irpw_line_if.sink                             samples,
	irpw_frame_if.source                          frames,
	input  logic                                  cfg_we,
	input  logic [irpw_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [irpw_pkg::CFG_WIDTH-1:0]        cfg_wdata
);

	localparam int QUEUE_DEPTH = 2;

	irpw_pkg::timing_t timing_q;
	logic              valid_s1;
	logic              line_s1;
	logic              step;
	logic              res_valid;
	irpw_pkg::frame_t  res;
	irpw_pkg::frame_t  queue_q [QUEUE_DEPTH];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic              pop;
	irpw_pkg::frame_t  head;

	// Timing register writes; unknown index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.first_delay <= irpw_pkg::FIRST_DELAY_RESET;
			timing_q.zero_period <= irpw_pkg::ZERO_PERIOD_RESET;
			timing_q.one_period  <= irpw_pkg::ONE_PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				irpw_pkg::CFG_FIRST_DELAY:
					timing_q.first_delay <= cfg_wdata[irpw_pkg::TIMER_WIDTH-1:0];
				irpw_pkg::CFG_ZERO_PERIOD:
					timing_q.zero_period <= cfg_wdata[irpw_pkg::TIMER_WIDTH-1:0];
				irpw_pkg::CFG_ONE_PERIOD:
					timing_q.one_period  <= cfg_wdata[irpw_pkg::TIMER_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Input stage: sample advances when the queue has room
	assign step          = valid_s1 && (count_q != 2'(QUEUE_DEPTH));
	assign samples.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			line_s1 <= samples.line_level;
		end
	end

	irpw_frame_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.line_level (line_s1),
		.timing     (timing_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	// Output queue
	assign push = res_valid;
	assign pop  = frames.valid && frames.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= res;
		end
	end

	assign head                  = queue_q[rd_ptr_q];
	assign frames.valid          = (count_q != '0);
	assign frames.frame_word     = head.frame_word;
	assign frames.command_code   = head.command_code;
	assign frames.device_address = head.device_address;
	assign frames.key_kind       = head.key_kind;

endmodule

>>> design/irpw_checker.sv
// Port-level checks for the IR pulse-width frame decoder, bound to its top level.
// Depends on irpw_pkg and on the top level's channel ports.
module irpw_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [irpw_pkg::WORD_WIDTH-1:0]     frame_word,
	input logic [irpw_pkg::CMD_WIDTH-1:0]      command_code,
	input logic [irpw_pkg::ADDR_WIDTH-1:0]     device_address,
	input logic [irpw_pkg::KEY_WIDTH-1:0]      key_kind
);

	// A stalled frame stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("frame dropped while stalled");

	// Command and address are the two parts of the frame word
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (command_code == frame_word[irpw_pkg::CMD_WIDTH-1:0]) &&
			(device_address == frame_word[irpw_pkg::WORD_WIDTH-1:irpw_pkg::CMD_WIDTH]))
		else $error("command or address does not match frame word");

	// Key kind follows the command code
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> key_kind == irpw_pkg::key_of(command_code))
		else $error("key kind does not match command");

	// With nothing pending at the output, samples are always taken
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind ir_pulse_width_frame_decoder irpw_checker u_irpw_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (samples.ready),
	.out_valid      (frames.valid),
	.out_ready      (frames.ready),
	.frame_word     (frames.frame_word),
	.command_code   (frames.command_code),
	.device_address (frames.device_address),
	.key_kind       (frames.key_kind)
);
